[sv/hrr_pkg.sv]
// shared types and constants for the health-aware round-robin unit
// no dependencies

package hrr_pkg;

    localparam int NODES_DEF     = 16;
    localparam int OP_W          = 3;
    localparam int NODE_INDEX_W  = 4;
    localparam int NODE_COUNT_W  = 5;
    localparam int FAIL_LIMIT_W  = 8;
    localparam int FAIL_CNT_W    = 8;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 8;
    localparam int INDEX_LIMIT   = 2 ** NODE_INDEX_W;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RST = NODE_COUNT_W'(0);
    localparam logic [FAIL_LIMIT_W-1:0] FAIL_LIMIT_RST = FAIL_LIMIT_W'(3);
    localparam logic [FAIL_CNT_W-1:0]   FAIL_CNT_MAX   = {FAIL_CNT_W{1'b1}};

    localparam logic [CFG_INDEX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAIL_LIMIT = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_SELECT = 3'd0,
        OP_RR     = 3'd1,
        OP_FAIL   = 3'd2,
        OP_OK     = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DISP  = 7'b0000010,
        S_MOD   = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_UPD   = 7'b0010000,
        S_COUNT = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load;
        logic ptr_sub;
        logic take;
        logic set_rr;
        logic scan_adv;
        logic scan_hit;
        logic miss_all;
        logic mark_fail;
        logic mark_ok;
        logic clear_all;
        logic cnt_init;
        logic cnt_step;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            n_zero;
        logic            ptr_ge_n;
        logic            hit;
        logic            last_try;
        logic            cnt_done;
    } t_sts;

endpackage

[sv/hrr_ctrl.sv]
// sequencing state machine for the health-aware round-robin unit
// depends on hrr_pkg; drives hrr_dp through t_cmd, reads t_sts

module hrr_ctrl import hrr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                unique case (t_op'(i_sts.op))
                    OP_SELECT, OP_RR: begin
                        if (i_sts.n_zero) begin
                            o_cmd.cnt_init = 1'b1;
                            n_state        = S_COUNT;
                        end else begin
                            n_state = S_MOD;
                        end
                    end
                    OP_FAIL, OP_OK: begin
                        n_state = S_UPD;
                    end
                    OP_CLEAR: begin
                        o_cmd.clear_all = 1'b1;
                        o_cmd.cnt_init  = 1'b1;
                        n_state         = S_COUNT;
                    end
                    default: begin
                        o_cmd.cnt_init = 1'b1;
                        n_state        = S_COUNT;
                    end
                endcase
            end
            S_MOD: begin
                if (i_sts.ptr_ge_n) begin
                    o_cmd.ptr_sub = 1'b1;
                end else begin
                    o_cmd.take = 1'b1;
                    if (t_op'(i_sts.op) == OP_SELECT) begin
                        n_state = S_SCAN;
                    end else begin
                        o_cmd.set_rr   = 1'b1;
                        o_cmd.cnt_init = 1'b1;
                        n_state        = S_COUNT;
                    end
                end
            end
            S_SCAN: begin
                priority if (i_sts.hit) begin
                    o_cmd.scan_hit = 1'b1;
                    o_cmd.cnt_init = 1'b1;
                    n_state        = S_COUNT;
                end else if (i_sts.last_try) begin
                    o_cmd.miss_all = 1'b1;
                    o_cmd.cnt_init = 1'b1;
                    n_state        = S_COUNT;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                end
            end
            S_UPD: begin
                if (t_op'(i_sts.op) == OP_FAIL) begin
                    o_cmd.mark_fail = 1'b1;
                end else begin
                    o_cmd.mark_ok = 1'b1;
                end
                o_cmd.cnt_init = 1'b1;
                n_state        = S_COUNT;
            end
            S_COUNT: begin
                if (i_sts.cnt_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.cnt_step = 1'b1;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/hrr_dp.sv]
// datapath: configuration, failure counters, pointer, scan index and result registers
// depends on hrr_pkg; controlled by hrr_ctrl

module hrr_dp import hrr_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [NODE_INDEX_W-1:0] i_node_index,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    output logic [NODE_INDEX_W-1:0] o_chosen_node,
    output logic                    o_found,
    output logic                    o_all_failed_reset,
    output logic [NODE_COUNT_W-1:0] o_available_count
);

    // only indices reachable by node_index can ever hold a non-zero count
    localparam int STORE = (NODES < INDEX_LIMIT) ? NODES : INDEX_LIMIT;
    localparam int IW    = (STORE > 1) ? $clog2(STORE) : 1;

    logic [NODE_COUNT_W-1:0] r_node_count;
    logic [FAIL_LIMIT_W-1:0] r_fail_limit;
    logic [OP_W-1:0]         r_op;
    logic [NODE_COUNT_W-1:0] r_ptr;
    logic [NODE_COUNT_W-1:0] r_start;
    logic [NODE_COUNT_W-1:0] r_k;
    logic [NODE_COUNT_W-1:0] r_tried;
    logic [NODE_COUNT_W-1:0] r_avail;
    logic [NODE_INDEX_W-1:0] r_chosen;
    logic                    r_found;
    logic                    r_cleared;
    logic [FAIL_CNT_W-1:0]   r_counts [STORE];

    logic [NODE_COUNT_W-1:0] w_n;
    logic [FAIL_CNT_W-1:0]   w_cnt_rd;
    logic                    w_in_store;
    logic                    w_hit;
    logic [NODE_COUNT_W-1:0] w_ptr_inc;
    logic [NODE_COUNT_W-1:0] w_k_inc;

    assign w_n        = (32'(r_node_count) > NODES) ? NODE_COUNT_W'(NODES) : r_node_count;
    assign w_in_store = (32'(r_k) < STORE);
    assign w_cnt_rd   = w_in_store ? r_counts[r_k[IW-1:0]] : '0;
    assign w_hit      = (w_cnt_rd < r_fail_limit);
    assign w_ptr_inc  = r_ptr + NODE_COUNT_W'(1);
    assign w_k_inc    = r_k + NODE_COUNT_W'(1);

    assign o_sts.op       = r_op;
    assign o_sts.n_zero   = (w_n == '0);
    assign o_sts.ptr_ge_n = (r_ptr >= w_n);
    assign o_sts.hit      = w_hit;
    assign o_sts.last_try = (r_tried == w_n - NODE_COUNT_W'(1));
    assign o_sts.cnt_done = (r_k >= w_n);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_fail_limit <= FAIL_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NODE_COUNT: r_node_count <= i_cfg_data[NODE_COUNT_W-1:0];
                CFG_FAIL_LIMIT: r_fail_limit <= i_cfg_data[FAIL_LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // round-robin pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_cmd.ptr_sub) begin
            r_ptr <= r_ptr - w_n;
        end else if (i_cmd.take) begin
            r_ptr <= (w_ptr_inc >= w_n) ? '0 : w_ptr_inc;
        end
    end

    // failure counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all || i_cmd.miss_all) begin
            for (int i = 0; i < STORE; i++) begin
                r_counts[i] <= '0;
            end
        end else if (w_in_store) begin
            if (i_cmd.mark_fail && (w_cnt_rd != FAIL_CNT_MAX)) begin
                r_counts[r_k[IW-1:0]] <= w_cnt_rd + FAIL_CNT_W'(1);
            end else if (i_cmd.mark_ok) begin
                r_counts[r_k[IW-1:0]] <= '0;
            end
        end
    end

    // transfer latch, scan index, tally and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation;
        end
        priority if (i_cmd.load) begin
            r_k <= NODE_COUNT_W'(i_node_index);
        end else if (i_cmd.cnt_init) begin
            r_k <= '0;
        end else if (i_cmd.take) begin
            r_k <= r_ptr;
        end else if (i_cmd.scan_adv) begin
            r_k <= (w_k_inc >= w_n) ? '0 : w_k_inc;
        end else if (i_cmd.cnt_step) begin
            r_k <= w_k_inc;
        end
        if (i_cmd.take) begin
            r_start <= r_ptr;
            r_tried <= '0;
        end else if (i_cmd.scan_adv) begin
            r_tried <= r_tried + NODE_COUNT_W'(1);
        end
        if (i_cmd.cnt_init) begin
            r_avail <= '0;
        end else if (i_cmd.cnt_step && w_hit) begin
            r_avail <= r_avail + NODE_COUNT_W'(1);
        end
        priority if (i_cmd.load) begin
            r_chosen  <= '0;
            r_found   <= 1'b0;
            r_cleared <= 1'b0;
        end else if (i_cmd.take && i_cmd.set_rr) begin
            r_chosen <= r_ptr[NODE_INDEX_W-1:0];
            r_found  <= 1'b1;
        end else if (i_cmd.scan_hit) begin
            r_chosen <= r_k[NODE_INDEX_W-1:0];
            r_found  <= 1'b1;
        end else if (i_cmd.miss_all) begin
            r_chosen  <= r_start[NODE_INDEX_W-1:0];
            r_found   <= 1'b1;
            r_cleared <= 1'b1;
        end
    end

    assign o_chosen_node      = r_chosen;
    assign o_found            = r_found;
    assign o_all_failed_reset = r_cleared;
    assign o_available_count  = r_avail;

endmodule

[sv/health_aware_round_robin_unit.sv]
// Round-robin node selector with per-node failure counters. One item is
// taken at a time: the input stall drops once the result has been transferred.
// With n the table size, a working-node select first reduces the pointer
// below n if node_count was lowered, then scans at most n counters, then
// tallies available nodes over the single counter read port. A plain
// round-robin step skips the scan, a mark updates one counter before the
// tally, a clear or an unused code goes straight to the tally, and a select
// on an empty table goes straight to an empty tally.
// Configuration should be written only while no item is in flight.
// top level; depends on hrr_pkg, hrr_ctrl, hrr_dp

module health_aware_round_robin_unit import hrr_pkg::*; #(
    parameter int NODES = NODES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [NODE_INDEX_W-1:0] i_node_index,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [NODE_INDEX_W-1:0] o_chosen_node,
    output logic                    o_found,
    output logic                    o_all_failed_reset,
    output logic [NODE_COUNT_W-1:0] o_available_count
);

    t_cmd w_cmd;
    t_sts w_sts;

    hrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    hrr_dp #(
        .NODES (NODES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_operation        (i_operation),
        .i_node_index       (i_node_index),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .o_chosen_node      (o_chosen_node),
        .o_found            (o_found),
        .o_all_failed_reset (o_all_failed_reset),
        .o_available_count  (o_available_count)
    );

endmodule
